// File: src/mmbd_pkg.sv
// ============================================================================
// mmbd_pkg - shared types and constants of the min/max bucket decimator
// Field widths, bucket sizing constants and the record passed from the
// front end through the queue to the output sequencer.
// ============================================================================
`default_nettype none

package mmbd_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int INDEX_BITS        = 20;
	localparam int COUNT_BITS        = 21;
	localparam int WIDTH_BITS        = 12;
	localparam int MAX_SAMPLES       = 1048576;
	localparam int TARGET_BUCKETS    = 500;
	localparam int PASSTHROUGH_LIMIT = 2002;
	localparam int SLOTS             = 4;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// Division by the bucket count is done as a multiplication by a rounded-up
	// reciprocal. With a 30-bit shift the error stays far below one step for
	// every 21-bit dividend, so the quotient is exact.
	localparam int          RECIP_SHIFT = 30;
	localparam int          RECIP_BITS  = 22;
	localparam longint      RECIP_WIDE  =
		((64'd1 << RECIP_SHIFT) + TARGET_BUCKETS - 1) / TARGET_BUCKETS;
	localparam logic [RECIP_BITS-1:0] RECIP_MULT = RECIP_BITS'(RECIP_WIDE);

	typedef struct packed {
		logic [INDEX_BITS-1:0]         index;
		logic signed [SAMPLE_BITS-1:0] value;
	} mmbd_entry_t;

	// One record per sample that causes output: up to four entries in index
	// order, a keep mask for the ones that survive duplicate removal, and the
	// end-of-series flag.
	typedef struct packed {
		mmbd_entry_t [SLOTS-1:0] slot;
		logic [SLOTS-1:0]        keep;
		logic                    series_end;
	} mmbd_rec_t;

endpackage

`default_nettype wire

// File: src/minmax_bucket_decimator_top.sv
// ============================================================================
// minmax_bucket_decimator_top - min/max bucket decimation of a sample stream
// Thins a series of signed samples to first/min/max/last points per bucket.
// ============================================================================
//
// Usage:
// - Write the series length on the cfg channel (cfg_valid/cfg_ready/cfg_data)
//   while the block is idle. The write restarts the series at position 0 and
//   sets the bucket width; cfg_ready is always high.
// - Samples enter on the s_* stream, one per transaction. Results leave on the
//   m_* stream: m_tlast marks the last result caused by one sample, m_tuser
//   marks the result of the final sample of the series.
// - Short series (up to the pass-through limit) keep every sample. Longer
//   ones keep sample 0, the final sample, and up to four points per bucket.
// - A result passes the queue and the output register before m_tvalid.
//   A sample is accepted every cycle while the queue is not full; a closing
//   bucket drains its up to four results through the output sequencer, and
//   as every bucket but the last holds at least five samples, output keeps pace.
// - When the receiver stalls, records wait in a four-deep queue; s_tready
//   falls only once that queue is full.
// - Reset sets the length to one sample and empties queue and output.
//
`default_nettype none

module minmax_bucket_decimator_top
	import mmbd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [COUNT_BITS-1:0] cfg_data,   // sample_count
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [15:0]           s_tdata,    // [15:0] sample_value
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [39:0]           m_tdata,    // [19:0] kept_index, [35:20] kept_value
	output      logic                  m_tlast,    // run_end
	output      logic                  m_tuser     // [0] series_end
);

	logic        accept, push, full, pop, head_valid;
	mmbd_rec_t   wr_rec, head_rec;
	mmbd_entry_t out_entry;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;

	mmbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.sample    (signed'(s_tdata[SAMPLE_BITS-1:0])),
		.push      (push),
		.rec       (wr_rec)
	);

	mmbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_rec     (wr_rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	mmbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_rec       (head_rec),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_entry      (out_entry),
		.out_run_end    (m_tlast),
		.out_series_end (m_tuser)
	);

	// Index in the low bits, value above it, zero padding to whole bytes.
	assign m_tdata = 40'({out_entry.value, out_entry.index});

endmodule

`default_nettype wire

// File: src/mmbd_front.sv
// ============================================================================
// mmbd_front - sample intake and bucket tracking
// Holds the series configuration, follows the position in the series and
// the running first/min/max of the open bucket, and builds an output record
// whenever a sample is passed through or a bucket closes.
// ============================================================================
`default_nettype none

module mmbd_front
	import mmbd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [COUNT_BITS-1:0]         cfg_data,
	input  wire logic                          accept,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output      logic                          push,
	output      mmbd_rec_t                     rec
);

	// Configuration
	logic [INDEX_BITS-1:0] cnt_m1_q;
	logic [INDEX_BITS-1:0] cnt_m2_q;
	logic                  pass_q;
	logic [WIDTH_BITS-1:0] width_q;

	logic [COUNT_BITS-1:0]            eff;
	logic [COUNT_BITS-1:0]            dividend;
	logic [COUNT_BITS+RECIP_BITS-1:0] prod;
	logic                             pass_n;

	always_comb begin
		if (cfg_data == '0) begin
			eff = COUNT_BITS'(1);
		end else if (cfg_data > COUNT_BITS'(MAX_SAMPLES)) begin
			eff = COUNT_BITS'(MAX_SAMPLES);
		end else begin
			eff = cfg_data;
		end
		pass_n   = (eff <= COUNT_BITS'(PASSTHROUGH_LIMIT));
		dividend = eff + COUNT_BITS'(TARGET_BUCKETS - 3);
		prod     = (COUNT_BITS+RECIP_BITS)'(dividend) * (COUNT_BITS+RECIP_BITS)'(RECIP_MULT);
	end

	// Series and bucket state
	logic [INDEX_BITS-1:0]         pos_q;
	logic [WIDTH_BITS-1:0]         fill_q;
	logic [INDEX_BITS-1:0]         prev_q;
	logic [INDEX_BITS-1:0]         first_idx_q, min_idx_q, max_idx_q;
	logic signed [SAMPLE_BITS-1:0] first_val_q, min_val_q, max_val_q;

	logic                          final_s, direct, fresh, close;
	logic [WIDTH_BITS-1:0]         fill_n;
	logic [INDEX_BITS-1:0]         f_idx, mn_idx, mx_idx, lo_idx, hi_idx;
	logic signed [SAMPLE_BITS-1:0] f_val, mn_val, mx_val, lo_val, hi_val;

	always_comb begin
		final_s = (pos_q == cnt_m1_q);
		direct  = pass_q || (pos_q == '0) || final_s;
		fresh   = (fill_q == '0);
		fill_n  = fill_q + WIDTH_BITS'(1);
		close   = (fill_n >= width_q) || (pos_q == cnt_m2_q);

		f_idx = fresh ? pos_q  : first_idx_q;
		f_val = fresh ? sample : first_val_q;
		if (fresh || sample < min_val_q) begin
			mn_idx = pos_q;
			mn_val = sample;
		end else begin
			mn_idx = min_idx_q;
			mn_val = min_val_q;
		end
		if (fresh || sample > max_val_q) begin
			mx_idx = pos_q;
			mx_val = sample;
		end else begin
			mx_idx = max_idx_q;
			mx_val = max_val_q;
		end
		if (mx_idx < mn_idx) begin
			lo_idx = mx_idx;
			lo_val = mx_val;
			hi_idx = mn_idx;
			hi_val = mn_val;
		end else begin
			lo_idx = mn_idx;
			lo_val = mn_val;
			hi_idx = mx_idx;
			hi_val = mx_val;
		end

		rec = '0;
		if (direct) begin
			rec.slot[0]    = '{index: pos_q, value: sample};
			rec.keep       = SLOTS'(1);
			rec.series_end = final_s;
		end else if (close) begin
			rec.slot[0] = '{index: f_idx, value: f_val};
			rec.slot[1] = '{index: lo_idx, value: lo_val};
			rec.slot[2] = '{index: hi_idx, value: hi_val};
			rec.slot[3] = '{index: pos_q, value: sample};
			// An index equal to the one before it is dropped.
			rec.keep[0] = (f_idx != prev_q);
			rec.keep[1] = (lo_idx != f_idx);
			rec.keep[2] = (hi_idx != lo_idx);
			rec.keep[3] = (pos_q != hi_idx);
		end
		push = accept && (rec.keep != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_m1_q <= '0;
			cnt_m2_q <= '1;
			pass_q   <= 1'b1;
			width_q  <= '0;
			pos_q    <= '0;
			fill_q   <= '0;
			prev_q   <= '0;
		end else if (cfg_valid) begin
			cnt_m1_q <= INDEX_BITS'(eff - COUNT_BITS'(1));
			cnt_m2_q <= INDEX_BITS'(eff - COUNT_BITS'(2));
			pass_q   <= pass_n;
			width_q  <= pass_n ? '0 : prod[RECIP_SHIFT +: WIDTH_BITS];
			pos_q    <= '0;
			fill_q   <= '0;
			prev_q   <= '0;
		end else if (accept) begin
			if (final_s) begin
				pos_q  <= '0;
				fill_q <= '0;
				prev_q <= '0;
			end else begin
				pos_q <= pos_q + INDEX_BITS'(1);
				if (direct) begin
					prev_q <= pos_q;
				end else if (close) begin
					fill_q <= '0;
					prev_q <= pos_q;
				end else begin
					fill_q <= fill_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !direct) begin
			first_idx_q <= f_idx;
			first_val_q <= f_val;
			min_idx_q   <= mn_idx;
			min_val_q   <= mn_val;
			max_idx_q   <= mx_idx;
			max_val_q   <= mx_val;
		end
	end

endmodule

`default_nettype wire

// File: src/mmbd_queue.sv
// ============================================================================
// mmbd_queue - short record queue between front end and output sequencer
// A small circular buffer of output records with occupancy tracking.
// ============================================================================
`default_nettype none

module mmbd_queue
	import mmbd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mmbd_rec_t wr_rec,
	output      logic      full,
	input  wire logic      pop,
	output      logic      head_valid,
	output      mmbd_rec_t head_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mmbd_rec_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

`default_nettype wire

// File: src/mmbd_back.sv
// ============================================================================
// mmbd_back - output sequencer
// Walks the kept entries of the head record into the output register, one per
// cycle unless the output stalls, and retires the record with its last entry.
// ============================================================================
`default_nettype none

module mmbd_back
	import mmbd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_valid,
	input  wire mmbd_rec_t               head_rec,
	output      logic                    pop,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      mmbd_entry_t             out_entry,
	output      logic                    out_run_end,
	output      logic                    out_series_end
);

	logic [SLOTS-1:0] done_q;
	logic [SLOTS-1:0] rem, sel;
	logic             last, load;
	mmbd_entry_t      pick;

	always_comb begin
		rem  = head_rec.keep & ~done_q;
		sel  = rem & (~rem + SLOTS'(1));
		last = ((rem & ~sel) == '0);
		pick = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (sel[i]) begin
				pick = head_rec.slot[i];
			end
		end
		load = head_valid && (!out_valid || out_ready);
		pop  = load && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				done_q    <= last ? '0 : (done_q | sel);
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_entry      <= pick;
			out_run_end    <= last;
			out_series_end <= head_rec.series_end && last;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_minmax_bucket_decimator_checker.sv
// ----------------------------------------------------------------------------
// tb_minmax_bucket_decimator_checker - result prediction and comparison
// Watches the configuration, sample and result channels of the decimator,
// keeps its own copy of the bucket state and checks every result transaction
// against the oldest predicted kept sample.
// ----------------------------------------------------------------------------
module tb_minmax_bucket_decimator_checker
	import mmbd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [COUNT_BITS-1:0] cfg_data,   // sample_count
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [15:0]           s_tdata,    // [15:0] sample_value
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [39:0]           m_tdata,    // [19:0] kept_index, [35:20] kept_value
	input  wire logic                  m_tlast,    // run_end
	input  wire logic                  m_tuser,    // [0] series_end
	output int                         fail_count,
	output int                         pending
);

	localparam int VALUE_LSB   = INDEX_BITS;
	localparam int REPORT_CAP  = 100;

	typedef struct packed {
		logic [INDEX_BITS-1:0]         index;
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          run_end;
		logic                          series_end;
	} kept_t;

	kept_t                         kept_q[$];
	kept_t                         burst[$];
	kept_t                         want;
	int unsigned                   series_len;
	int unsigned                   position;
	int unsigned                   bucket_width;
	int unsigned                   bucket_fill;
	int unsigned                   first_idx;
	int unsigned                   min_idx;
	int unsigned                   max_idx;
	int unsigned                   last_kept_idx;
	logic signed [SAMPLE_BITS-1:0] first_val;
	logic signed [SAMPLE_BITS-1:0] min_val;
	logic signed [SAMPLE_BITS-1:0] max_val;
	int                            mismatches = 0;

	assign fail_count = mismatches;

	function automatic void restart_series();
		position      = 0;
		bucket_fill   = 0;
		first_idx     = 0;
		first_val     = '0;
		min_idx       = 0;
		min_val       = '0;
		max_idx       = 0;
		max_val       = '0;
		last_kept_idx = 0;
	endfunction

	// A length of zero counts as one sample; lengths past the maximum are clamped.
	function automatic void load_length(input logic [COUNT_BITS-1:0] raw);
		if (raw == 0)
			series_len = 1;
		else if (raw > MAX_SAMPLES)
			series_len = MAX_SAMPLES;
		else
			series_len = 32'(raw);
		if (series_len > PASSTHROUGH_LIMIT)
			bucket_width = (series_len - 2 + TARGET_BUCKETS - 1) / TARGET_BUCKETS;
		else
			bucket_width = 0;
		restart_series();
	endfunction

	function automatic void push_kept(input int unsigned idx,
			input logic signed [SAMPLE_BITS-1:0] v, input bit closes_series);
		kept_t k;
		k.index      = INDEX_BITS'(idx);
		k.value      = v;
		k.run_end    = 1'b0;
		k.series_end = closes_series;
		burst = {burst, k};
	endfunction

	// Bucket points repeating the index kept just before are dropped.
	function automatic void push_distinct(input int unsigned idx,
			input logic signed [SAMPLE_BITS-1:0] v);
		if (idx == last_kept_idx)
			return;
		last_kept_idx = idx;
		push_kept(idx, v, 1'b0);
	endfunction

	function automatic void decimate_sample(input logic signed [SAMPLE_BITS-1:0] v);
		int unsigned                   p;
		bit                            closes_series;
		int unsigned                   lo_i;
		int unsigned                   hi_i;
		logic signed [SAMPLE_BITS-1:0] lo_v;
		logic signed [SAMPLE_BITS-1:0] hi_v;
		p             = position;
		closes_series = (p + 1 >= series_len);
		burst.delete();
		if (bucket_width == 0 || p == 0 || closes_series) begin
			push_kept(p, v, closes_series);
			last_kept_idx = p;
		end else begin
			if (bucket_fill == 0) begin
				first_idx = p;
				first_val = v;
				min_idx   = p;
				min_val   = v;
				max_idx   = p;
				max_val   = v;
			end else begin
				// Strict comparisons keep the earliest sample on ties.
				if (v < min_val) begin
					min_idx = p;
					min_val = v;
				end
				if (v > max_val) begin
					max_idx = p;
					max_val = v;
				end
			end
			bucket_fill++;
			if (bucket_fill >= bucket_width || p + 2 == series_len) begin
				lo_i = min_idx;
				lo_v = min_val;
				hi_i = max_idx;
				hi_v = max_val;
				if (hi_i < lo_i) begin
					lo_i = max_idx;
					lo_v = max_val;
					hi_i = min_idx;
					hi_v = min_val;
				end
				push_distinct(first_idx, first_val);
				push_distinct(lo_i, lo_v);
				push_distinct(hi_i, hi_v);
				push_distinct(p, v);
				bucket_fill = 0;
			end
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].run_end = 1'b1;
		foreach (burst[i])
			kept_q = {kept_q, burst[i]};
		if (closes_series)
			restart_series();
		else
			position = p + 1;
	endfunction

	initial begin
		load_length(COUNT_BITS'(1));
		pending = 0;
	end

	// Results are compared before the same edge's sample is predicted: a result
	// never leaves in the cycle its sample is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_length(COUNT_BITS'(1));
			kept_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (kept_q.size() == 0) begin
					if (mismatches < REPORT_CAP)
						$display("%0t: unexpected result, expected none, got index %0d",
							$time, m_tdata[INDEX_BITS-1:0],
							" value %0d last %b series_end %b",
							$signed(m_tdata[VALUE_LSB +: SAMPLE_BITS]), m_tlast, m_tuser);
					mismatches++;
				end else begin
					want = kept_q.pop_front();
					if (want.index !== m_tdata[INDEX_BITS-1:0]
							|| want.value !== m_tdata[VALUE_LSB +: SAMPLE_BITS]
							|| want.run_end !== m_tlast
							|| want.series_end !== m_tuser) begin
						if (mismatches < REPORT_CAP)
							$display("%0t: result mismatch, expected index %0d value %0d",
								$time, want.index, $signed(want.value),
								" last %b series_end %b,", want.run_end, want.series_end,
								" got index %0d value %0d last %b series_end %b",
								m_tdata[INDEX_BITS-1:0],
								$signed(m_tdata[VALUE_LSB +: SAMPLE_BITS]), m_tlast, m_tuser);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				load_length(cfg_data);
			if (s_tvalid && s_tready)
				decimate_sample(s_tdata);
		end
		pending = kept_q.size();
	end

endmodule

// File: tb/sv/tb_minmax_bucket_decimator_top.sv
// ----------------------------------------------------------------------------
// tb_minmax_bucket_decimator_top - testbench of the min/max bucket decimator
// Drives series lengths and samples into the block with random gaps and
// back-pressure, and leaves prediction and checking of the kept samples to
// the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_minmax_bucket_decimator_top;
	import mmbd_pkg::*;

	// Some 120 samples are sent. In the worst case each waits the longest gap
	// and causes four results that each wait the longest stall, plus one long
	// hold-off and the short waits around the length writes; the limit leaves a
	// wide margin on top of that.
	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_WAIT_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [COUNT_BITS-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;    // [15:0] sample_value
	logic                  m_tvalid;
	logic                  m_tready;
	logic [39:0]           m_tdata;    // [19:0] kept_index, [35:20] kept_value
	logic                  m_tlast;    // run_end
	logic                  m_tuser;    // [0] series_end

	int   fail_count;
	int   pending;
	int   cycles = 0;
	// When set, neither side idles: gives stretches at full rate.
	logic quiet = 1'b0;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	logic hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	minmax_bucket_decimator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	tb_minmax_bucket_decimator_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Idle lengths for both sides: mostly none, sometimes a few cycles, and
	// now and then a long pause.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Sample values: a good share from a narrow band around zero so that
	// buckets see equal minima and maxima, some at the very ends of the range,
	// the rest anywhere.
	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return 16'($urandom_range(0, 6)) - 16'd3;
		if (r == 3)
			return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		return 16'($urandom);
	endfunction

	// One sample transaction. The valid is only lowered when a gap is wanted,
	// so back-to-back samples keep it high without a glitch.
	task automatic send_sample(input logic [15:0] v);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int n);
		repeat (n)
			send_sample(pick_sample());
	endtask

	// Stops offering samples until every predicted result has been taken, then
	// waits a little longer in case a sample that causes no result is still
	// being absorbed.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// A length write restarts the series, so it is only made once the block
	// has gone idle.
	task automatic write_length(input logic [COUNT_BITS-1:0] len);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, and on request one long hold-off counted here.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (gap - 1)
						@(negedge clk);
				end
			end
		end
	end

	// Watchdog on the total run time.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, cycles);
			$display("FAIL minmax_bucket_decimator_top");
			$finish;
		end
	end

	initial begin
		logic [15:0]           shaped[10];
		logic [COUNT_BITS-1:0] len;
		int                    n;
		int                    waited;

		// Two buckets with the extreme values in awkward places: the first has
		// its maximum and minimum repeated so that the earliest ones must be
		// chosen, the second has its minimum on the closing sample, which then
		// must not be kept twice.
		shaped = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'hFFFB};

		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Out of reset the series is one sample long, so each
		// sample is both the first and the final one.
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// A zero length behaves like a length of one.
		write_length('0);
		send_sample(16'h0000);
		send_sample(16'hFFFF);

		// Two-sample series; the third sample wraps round into a new series.
		write_length(COUNT_BITS'(2));
		send_sample(16'h0005);
		send_sample(16'h0006);
		send_sample(16'h0007);

		// Longest series that is still passed through whole.
		write_length(COUNT_BITS'(PASSTHROUGH_LIMIT));
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h1234);

		// Shortest series that is bucketed: buckets of five samples.
		write_length(COUNT_BITS'(PASSTHROUGH_LIMIT + 1));
		send_sample(16'h0009);
		// A flat bucket: only its first and last samples are kept.
		repeat (5)
			send_sample(16'h0064);
		foreach (shaped[i])
			send_sample(shaped[i]);

		// A bucketed series with buckets of five samples. Along the way the
		// receiver holds off for a long stretch while samples keep coming, so
		// the internal queue fills and the input stalls; later the sender
		// waits for every result, and then both sides run at full rate.
		write_length(COUNT_BITS'(2010));
		send_random(20);
		hold_req = 1'b1;
		send_random(30);
		drain_results();
		quiet = 1'b1;
		send_random(12);
		quiet = 1'b0;
		send_random(8);

		// Length beyond the maximum, clamped: very wide buckets, so only the
		// first sample of the series gives a result.
		write_length('1);
		quiet = 1'b1;
		send_random(5);
		quiet = 1'b0;

		// Exactly the maximum length, abandoned early by the next write.
		write_length(COUNT_BITS'(MAX_SAMPLES));
		send_random(3);

		// Random lengths, each series cut short or wrapped by the next write.
		repeat (2) begin
			case ($urandom_range(0, 2))
				0: begin
					len = COUNT_BITS'($urandom_range(1, 6));
					n   = int'(len) + int'($urandom_range(0, 3));
				end
				1: begin
					len = COUNT_BITS'($urandom_range(2003, 3000));
					n   = int'($urandom_range(6, 10));
				end
				default: begin
					len = COUNT_BITS'($urandom);
					n   = int'($urandom_range(3, 6));
				end
			endcase
			write_length(len);
			send_random(n);
		end

		// Wind down: wait for the outstanding results, with a bound, and then a
		// few more cycles to catch anything unexpected.
		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < END_WAIT_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (20)
			@(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("PASS minmax_bucket_decimator_top");
		end else begin
			if (pending != 0)
				$display("%0t: %0d expected results never arrived", $time, pending);
			$display("FAIL minmax_bucket_decimator_top");
		end
		$finish;
	end

endmodule
